// ===== sv/lrwc_pkg.sv =====
// Shared types and codes for the least-recently-written key/revision cache.
`default_nettype none
package lrwc_pkg;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned REV_W = 64;

  // Operation codes carried on the input tuser bit.
  localparam logic FUNC_PUT = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  // Status codes of a result word.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  // One cache entry as it travels from a cell to its older neighbor.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [REV_W-1:0] rev;
  } entry_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic             put;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== sv/lrwc_cell.sv =====
// One cache cell: holds an entry, matches the query key and shifts toward older cells.
`default_nettype none
module lrwc_cell (
  input  wire                        clk,
  input  wire                        rst_n,
  input  lrwc_pkg::cell_ctl_t        ctl,
  input  lrwc_pkg::entry_t           newer,
  input  wire                        hit_older,
  input  wire                        any_hit,
  input  wire [lrwc_pkg::REV_W-1:0]  rev_older,
  output lrwc_pkg::entry_t           cur,
  output logic                       hit_here_or_older,
  output logic [lrwc_pkg::REV_W-1:0] rev_acc
);
  import lrwc_pkg::*;

  logic             valid_r;
  logic             valid_nxt;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;
  logic [REV_W-1:0] rev_r;
  logic [REV_W-1:0] rev_nxt;
  logic             match;
  logic             shift_en;

  // Local compare against the broadcast key; empty cells never match.
  assign match             = valid_r && (key_r == ctl.key);
  assign hit_here_or_older = match || hit_older;
  assign rev_acc           = rev_older | (match ? rev_r : '0);

  // On a put the cell takes its newer neighbor's entry when the hit lies here
  // or further back, or when the key missed everywhere.
  assign shift_en = ctl.put && (!any_hit || hit_here_or_older);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    rev_nxt   = rev_r;
    if (shift_en) begin
      valid_nxt = newer.valid;
      key_nxt   = newer.key;
      rev_nxt   = newer.rev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    rev_r <= rev_nxt;
  end

  assign cur.valid = valid_r;
  assign cur.key   = key_r;
  assign cur.rev   = rev_r;

endmodule
`default_nettype wire

// ===== sv/lrw_key_value_cache_core.sv =====
// Top level of the least-recently-written key/revision cache built as a row of cells.
//
// Channel | Dir | Handshake            | Payload
// in_     | in  | in_tvalid/in_tready   | tuser: func; tdata: key, revision
// out_    | out | out_tvalid/out_tready | tdata: status, hit, revision_out
//
// Each word is first captured, then compared against every cell in parallel
// while the cell row is updated. Cells are kept in write order (cell 0
// newest), so the last valid cell is always the one to evict.
// Reset is synchronous, active low, and empties every cell at once.
// A stalled result holds in the output register and blocks the next word.
`default_nettype none
module lrw_key_value_cache_core #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [127:0] in_tdata,   // [63:0] key, [127:64] revision
  input  wire          in_tuser,   // [0] func
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [71:0]  out_tdata   // [0] status, [1] hit, [65:2] revision_out, zero pad
);
  import lrwc_pkg::*;

  logic             busy_r;
  logic             busy_nxt;
  logic             func_r;
  logic [KEY_W-1:0] key_r;
  logic [REV_W-1:0] rev_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_status_r;
  logic             out_hit_r;
  logic [REV_W-1:0] out_rev_r;

  logic             in_acc;
  logic             exec;
  logic             key_zero;
  logic             is_get;
  cell_ctl_t        ctl;
  entry_t           new_entry;
  entry_t           ent  [ENTRIES];
  logic             hit_chain [ENTRIES+1];
  logic [REV_W-1:0] rev_chain [ENTRIES+1];

  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;
  assign exec      = busy_r && (!out_valid_r || out_tready);
  assign key_zero  = (key_r == '0);
  assign is_get    = (func_r == FUNC_GET);

  // Capture stage.
  always_comb begin
    busy_nxt = busy_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (exec) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_tuser;
      key_r  <= in_tdata[KEY_W-1:0];
      rev_r  <= in_tdata[KEY_W+REV_W-1:KEY_W];
    end
  end

  // Broadcast to the cell row; a put with key zero leaves the row alone.
  assign ctl.put         = exec && !is_get && !key_zero;
  assign ctl.key         = key_r;
  assign new_entry.valid = 1'b1;
  assign new_entry.key   = key_r;
  assign new_entry.rev   = rev_r;

  assign hit_chain[ENTRIES] = 1'b0;
  assign rev_chain[ENTRIES] = '0;

  // Row of cells, newest at index 0; a put moves entries up to the hit (all on a miss) one cell older.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      lrwc_cell u_cell (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .newer             (new_entry),
        .hit_older         (hit_chain[i+1]),
        .any_hit           (hit_chain[0]),
        .rev_older         (rev_chain[i+1]),
        .cur               (ent[i]),
        .hit_here_or_older (hit_chain[i]),
        .rev_acc           (rev_chain[i])
      );
    end else begin : g_body
      lrwc_cell u_cell (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .newer             (ent[i-1]),
        .hit_older         (hit_chain[i+1]),
        .any_hit           (hit_chain[0]),
        .rev_older         (rev_chain[i+1]),
        .cur               (ent[i]),
        .hit_here_or_older (hit_chain[i]),
        .rev_acc           (rev_chain[i])
      );
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_status_r <= (!is_get && key_zero) ? STATUS_INVALID : STATUS_OK;
      out_hit_r    <= is_get && hit_chain[0];
      out_rev_r    <= (is_get && hit_chain[0]) ? rev_chain[0] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_rev_r, out_hit_r, out_status_r};

endmodule
`default_nettype wire

// ===== sv/lrwc_checker.sv =====
// Port-level checks for the cache core, attached by bind.
`default_nettype none
module lrwc_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tvalid,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [71:0]  out_tdata
);
  import lrwc_pkg::*;

  // A stalled result word holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // One word in flight: the input closes right after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // A result is either a rejected put or a lookup hit, never both.
  a_status_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("status and hit both set");

  // Revision is zero unless the word reports a hit.
  a_rev_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> (out_tdata[65:2] == '0))
    else $error("revision set without hit");

  // The input has no effect on a pending result.
  a_in_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##1 (out_tvalid == $past(out_tvalid && !out_tready)))
    else $error("result appeared in the capture cycle");

endmodule

bind lrw_key_value_cache_core lrwc_checker u_lrwc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the least-recently-written key/revision cache core.
`default_nettype none
module tb_top;
  import lrwc_pkg::*;

  localparam int unsigned CACHE_ENTRIES   = 16;
  localparam int unsigned KEY_POOL        = 24;
  localparam int unsigned ITEMS_PER_PHASE = 206;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned MAX_PRINTED     = 100;

  // One request word and one result word as the cache sees them.
  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] key;
    logic [REV_W-1:0] rev;
  } cache_req_t;

  typedef struct packed {
    logic             status;
    logic             hit;
    logic [REV_W-1:0] rev;
  } cache_rsp_t;

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata   = '0;   // [63:0] key, [127:64] revision
  logic         in_tuser   = 1'b0; // [0] func
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;         // [0] status, [1] hit, [65:2] revision_out

  lrw_key_value_cache_core #(
    .ENTRIES(CACHE_ENTRIES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Shadow copy of the cache contents and its write clock.
  logic [KEY_W-1:0] shadow_keys   [CACHE_ENTRIES];
  logic [REV_W-1:0] shadow_revs   [CACHE_ENTRIES];
  logic [63:0]      shadow_stamps [CACHE_ENTRIES];
  int unsigned      shadow_fill   = 0;
  logic [63:0]      shadow_clock  = '0;

  cache_req_t       pending_reqs[$];
  cache_rsp_t       expected_rsps[$];
  cache_req_t       drive_req;
  cache_rsp_t       want_rsp;
  logic [KEY_W-1:0] key_pool [KEY_POOL];

  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  logic        hold_off       = 1'b0;
  int unsigned accepted_count = 0;
  int unsigned results_seen   = 0;
  int unsigned error_count    = 0;
  int unsigned put_count      = 0;
  int unsigned get_count      = 0;
  int unsigned hit_count      = 0;
  int unsigned reject_count   = 0;
  int unsigned evict_count    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the result of one request and updates the shadow cache.
  function automatic cache_rsp_t cache_apply(cache_req_t req);
    cache_rsp_t  rsp;
    int          found;
    int unsigned slot;
    rsp   = '0;
    found = -1;
    for (int unsigned n = 0; n < shadow_fill; n++) begin
      if (found < 0 && shadow_keys[n] == req.key) found = n;
    end
    if (req.func == FUNC_GET) begin
      get_count++;
      if (found >= 0) begin
        rsp.hit = 1'b1;
        rsp.rev = shadow_revs[found];
        hit_count++;
      end
      return rsp;
    end
    put_count++;
    if (req.key == '0) begin
      rsp.status = STATUS_INVALID;
      reject_count++;
      return rsp;
    end
    rsp.status   = STATUS_OK;
    shadow_clock = shadow_clock + 64'd1;
    if (found >= 0) begin
      slot = found;
    end else if (shadow_fill < CACHE_ENTRIES) begin
      slot = shadow_fill;
      shadow_fill++;
    end else begin
      // Full: the smallest stamp goes, lowest index on a tie.
      slot = 0;
      for (int unsigned n = 1; n < CACHE_ENTRIES; n++) begin
        if (shadow_stamps[n] < shadow_stamps[slot]) slot = n;
      end
      evict_count++;
    end
    shadow_keys[slot]   = req.key;
    shadow_revs[slot]   = req.rev;
    shadow_stamps[slot] = shadow_clock;
    return rsp;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (error_count < MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic queue_req(input logic func, input logic [KEY_W-1:0] key,
                           input logic [REV_W-1:0] rev);
    cache_req_t req;
    req.func = func;
    req.key  = key;
    req.rev  = rev;
    pending_reqs.push_back(req);
  endtask

  // Mostly keys from a pool a bit larger than the cache, so hits and
  // evictions both happen; some fresh random keys and some zero keys.
  task automatic queue_random(input int unsigned count);
    int unsigned      pick;
    logic [KEY_W-1:0] key;
    logic             func;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 5)       key = '0;
      else if (pick < 15) key = {$urandom, $urandom};
      else                key = key_pool[$urandom_range(KEY_POOL - 1)];
      func = ($urandom_range(99) < 45) ? FUNC_PUT : FUNC_GET;
      queue_req(func, key, {$urandom, $urandom});
    end
  endtask

  task automatic drain_phase;
    while (pending_reqs.size() != 0) @(negedge clk);
  endtask

  // Driver: presents the next pending word once the last one was taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        expected_rsps.push_back(cache_apply(drive_req));
        accepted_count++;
      end
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_req = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {drive_req.rev, drive_req.key};
        in_tuser  <= drive_req.func;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready, with random stalls and the long hold-off.
  always @(posedge clk) begin
    out_tready <= rst_n && !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // Monitor: compares each result word with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_rsps.size() == 0) begin
        flag_mismatch("result word arrived with nothing expected");
      end else begin
        want_rsp = expected_rsps.pop_front();
        if (out_tdata[0] !== want_rsp.status)
          flag_mismatch($sformatf("result %0d status %b, expected %b",
                                  results_seen, out_tdata[0], want_rsp.status));
        if (out_tdata[1] !== want_rsp.hit)
          flag_mismatch($sformatf("result %0d hit %b, expected %b",
                                  results_seen, out_tdata[1], want_rsp.hit));
        if (out_tdata[65:2] !== want_rsp.rev)
          flag_mismatch($sformatf("result %0d revision %h, expected %h",
                                  results_seen, out_tdata[65:2], want_rsp.rev));
      end
    end
  end

  // Long receiver hold-off early on, while the sender keeps offering words.
  initial begin
    @(negedge clk);
    while (!rst_n || accepted_count < 40) @(negedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    for (int unsigned i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty miss, zero key both ways, extreme keys and revisions,
    // update of a cached key, then fill the cache and force an eviction.
    queue_req(FUNC_GET, 64'd5, '0);
    queue_req(FUNC_PUT, '0, '1);
    queue_req(FUNC_GET, '0, '0);
    queue_req(FUNC_PUT, '1, '1);
    queue_req(FUNC_GET, '1, '0);
    queue_req(FUNC_PUT, 64'd1, '0);
    queue_req(FUNC_GET, 64'd1, '1);
    queue_req(FUNC_PUT, '1, 64'h5555_5555_5555_5555);
    queue_req(FUNC_GET, '1, '0);
    for (int unsigned i = 0; i < 15; i++)
      queue_req(FUNC_PUT, 64'hA5A5_5A5A_0F0F_F0F0 ^ i, 64'h1000 + i);
    queue_req(FUNC_GET, 64'd1, '0);

    // Random phases: no idling, sender idle, receiver stalling, both.
    queue_random(ITEMS_PER_PHASE);
    drain_phase();
    send_idle_pct = 58;
    queue_random(ITEMS_PER_PHASE);
    drain_phase();
    send_idle_pct = 0;
    stall_pct     = 58;
    queue_random(ITEMS_PER_PHASE);
    drain_phase();
    send_idle_pct = 18;
    stall_pct     = 18;
    queue_random(ITEMS_PER_PHASE);

    while (pending_reqs.size() != 0 || in_tvalid || expected_rsps.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Ran %0d puts (%0d with key zero, %0d evictions) and %0d gets (%0d hits).",
             put_count, reject_count, evict_count, get_count, hit_count);
    $display("Idling covered none, sender, receiver and both, plus a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
